FILE: rtl/bsl_pkg.sv
// Shared constants, codes and the command word for the sequence list cells.
package bsl_pkg;

    localparam int CAPACITY  = 64;
    localparam int KEY_WIDTH = 32;
    localparam int IDX_W     = $clog2(CAPACITY);
    localparam int CNT_W     = $clog2(CAPACITY + 1);
    localparam int POS_W     = 7;
    localparam int CMP_W     = (POS_W > CNT_W) ? POS_W : CNT_W;
    localparam int IN_KEY_W  = 32;
    localparam int OUT_CNT_W = 7;
    localparam int IN_DATA_W = 48;
    localparam int OUT_DATA_W = 48;
    localparam int OPC_W     = 3;

    typedef enum logic [OPC_W-1:0] {
        OPC_PUSH_FRONT = 3'd0,
        OPC_POP_FRONT  = 3'd1,
        OPC_INSERT     = 3'd2,
        OPC_GET        = 3'd3,
        OPC_PUSH_BACK  = 3'd4,
        OPC_POP_BACK   = 3'd5,
        OPC_ROTATE     = 3'd6
    } opc_t;

    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_REMOVE_FRONT,
        CELL_APPEND,
        CELL_ROTATE
    } cell_op_t;

    typedef struct packed {
        cell_op_t                     op;
        logic [CMP_W-1:0]             pos;
        logic [CMP_W-1:0]             count;
        logic signed [KEY_WIDTH-1:0]  key;
    } cell_cmd_t;

endpackage

FILE: rtl/bsl_cell.sv
// One storage cell of the list: holds a key and trades it with its neighbours.
module bsl_cell
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic [bsl_pkg::IDX_W-1:0]             idx,
    input  bsl_pkg::cell_cmd_t                    cmd,
    input  logic signed [bsl_pkg::KEY_WIDTH-1:0]  prev_key,
    input  logic signed [bsl_pkg::KEY_WIDTH-1:0]  next_key,
    input  logic signed [bsl_pkg::KEY_WIDTH-1:0]  head_key,
    output logic signed [bsl_pkg::KEY_WIDTH-1:0]  key,
    output logic                                  order,
    output logic [bsl_pkg::KEY_WIDTH-1:0]         rd_sel
);

    logic signed [bsl_pkg::KEY_WIDTH-1:0] key_reg;
    logic signed [bsl_pkg::KEY_WIDTH-1:0] key_next;
    logic                                 order_reg;
    logic                                 order_next;
    logic [bsl_pkg::CMP_W-1:0]            idx_w;
    logic [bsl_pkg::CMP_W-1:0]            idx_p1;

    assign idx_w  = bsl_pkg::CMP_W'(idx);
    assign idx_p1 = idx_w + bsl_pkg::CMP_W'(1);

    always_comb
    begin
        key_next = key_reg;
        unique case (cmd.op)
            bsl_pkg::CELL_HOLD:
            begin
                key_next = key_reg;
            end
            bsl_pkg::CELL_INSERT:
            begin
                if (idx_w > cmd.pos)
                begin
                    key_next = prev_key;
                end
                else if (idx_w == cmd.pos)
                begin
                    key_next = cmd.key;
                end
            end
            bsl_pkg::CELL_REMOVE_FRONT:
            begin
                key_next = next_key;
            end
            bsl_pkg::CELL_APPEND:
            begin
                if (idx_w == cmd.count)
                begin
                    key_next = cmd.key;
                end
            end
            bsl_pkg::CELL_ROTATE:
            begin
                // The last occupied cell takes the head; the occupied cells before it take their right neighbour.
                if (idx_p1 < cmd.count)
                begin
                    key_next = next_key;
                end
                else if (idx_p1 == cmd.count)
                begin
                    key_next = head_key;
                end
            end
            default:
            begin
                key_next = key_reg;
            end
        endcase
    end

    // A pair that reaches past the last occupied cell never breaks the order.
    assign order_next = (idx_p1 >= cmd.count) || (key_reg < next_key);

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            order_reg <= 1'b1;
        end
        else
        begin
            order_reg <= order_next;
        end
    end

    assign key    = key_reg;
    assign order  = order_reg;
    assign rd_sel = (idx_w == cmd.pos) ? key_reg : '0;

endmodule

FILE: rtl/bounded_sequence_list_top.sv
// Top level of the bounded sequence list: controller and the row of key cells.
//
// An ordered list of up to 64 signed keys held in a row of cells that shift in parallel.
// One word in gives one word out. An accepted word passes through the execute, ordering
// check and result states; the result register is loaded in the result state once the
// output register is free, and only then is the input ready again. A rotate adds a
// rotate state after execute, in which the row turns by one place per cycle until it has
// turned by shift_count places. The ascending flag comes from a registered compare in each
// cell between its key and its right neighbour. A finished result waits in the output
// register while the next word is accepted.
module bounded_sequence_list_top
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // position[6:0], shift_count[13:7], key_value[45:14], zero fill [47:46]
    input  logic [bsl_pkg::IN_DATA_W-1:0]       s_axis_tdata,
    // opcode[2:0]
    input  logic [bsl_pkg::OPC_W-1:0]           s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // ok[0], read_value[32:1], count[39:33], is_empty[40], ascending[41], zero fill [47:42]
    output logic [bsl_pkg::OUT_DATA_W-1:0]      m_axis_tdata
);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_EXEC   = 5'b00010,
        S_ROT    = 5'b00100,
        S_CHECK  = 5'b01000,
        S_FINISH = 5'b10000
    } state_t;

    state_t                                state_reg, state_next;
    bsl_pkg::opc_t                         op_reg, op_next;
    logic [bsl_pkg::POS_W-1:0]             pos_reg, pos_next;
    logic [bsl_pkg::POS_W-1:0]             shift_reg, shift_next;
    logic signed [bsl_pkg::KEY_WIDTH-1:0]  in_key_reg, in_key_next;
    logic [bsl_pkg::CNT_W-1:0]             count_reg, count_next;
    logic                                  ok_reg, ok_next;
    logic [bsl_pkg::IN_KEY_W-1:0]          rd_reg, rd_next;
    logic [bsl_pkg::CMP_W-1:0]             rot_left_reg, rot_left_next;
    logic                                  m_tvalid_reg, m_tvalid_next;
    logic                                  res_ok_reg, res_ok_next;
    logic [bsl_pkg::IN_KEY_W-1:0]          res_rd_reg, res_rd_next;
    logic [bsl_pkg::OUT_CNT_W-1:0]         res_count_reg, res_count_next;
    logic                                  res_empty_reg, res_empty_next;
    logic                                  res_asc_reg, res_asc_next;

    bsl_pkg::cell_cmd_t                    cmd;
    logic signed [bsl_pkg::KEY_WIDTH-1:0]  keys [bsl_pkg::CAPACITY];
    logic [bsl_pkg::KEY_WIDTH-1:0]         rd_sels [bsl_pkg::CAPACITY];
    logic [bsl_pkg::CAPACITY-1:0]          order_vec;
    logic [bsl_pkg::KEY_WIDTH-1:0]         rd_any;
    logic                                  accept;
    logic [bsl_pkg::CMP_W-1:0]             pos_w;
    logic [bsl_pkg::CMP_W-1:0]             shift_w;
    logic [bsl_pkg::CMP_W-1:0]             count_w;
    logic                                  has_room;

    assign accept   = s_axis_tvalid && s_axis_tready;
    assign pos_w    = bsl_pkg::CMP_W'(pos_reg);
    assign shift_w  = bsl_pkg::CMP_W'(shift_reg);
    assign count_w  = bsl_pkg::CMP_W'(count_reg);
    assign has_room = count_reg < bsl_pkg::CNT_W'(bsl_pkg::CAPACITY);

    // Row of cells.
    for (genvar i = 0; i < bsl_pkg::CAPACITY; i++)
    begin : g_cell
        logic signed [bsl_pkg::KEY_WIDTH-1:0] prev_w;
        logic signed [bsl_pkg::KEY_WIDTH-1:0] next_w;

        if (i == 0)
        begin : g_first
            assign prev_w = '0;
        end
        else
        begin : g_prev
            assign prev_w = keys[i-1];
        end

        if (i == bsl_pkg::CAPACITY - 1)
        begin : g_last
            assign next_w = '0;
        end
        else
        begin : g_next
            assign next_w = keys[i+1];
        end

        bsl_cell u_cell
        (
            .clk      (clk),
            .rst_n    (rst_n),
            .idx      (bsl_pkg::IDX_W'(i)),
            .cmd      (cmd),
            .prev_key (prev_w),
            .next_key (next_w),
            .head_key (keys[0]),
            .key      (keys[i]),
            .order    (order_vec[i]),
            .rd_sel   (rd_sels[i])
        );
    end

    always_comb
    begin
        rd_any = '0;
        for (int i = 0; i < bsl_pkg::CAPACITY; i++)
        begin
            rd_any = rd_any | rd_sels[i];
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        pos_next       = pos_reg;
        shift_next     = shift_reg;
        in_key_next    = in_key_reg;
        count_next     = count_reg;
        ok_next        = ok_reg;
        rd_next        = rd_reg;
        rot_left_next  = rot_left_reg;
        m_tvalid_next  = m_tvalid_reg && !m_axis_tready;
        res_ok_next    = res_ok_reg;
        res_rd_next    = res_rd_reg;
        res_count_next = res_count_reg;
        res_empty_next = res_empty_reg;
        res_asc_next   = res_asc_reg;

        cmd.op    = bsl_pkg::CELL_HOLD;
        cmd.pos   = pos_w;
        cmd.count = count_w;
        cmd.key   = in_key_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    op_next     = bsl_pkg::opc_t'(s_axis_tuser);
                    pos_next    = s_axis_tdata[6:0];
                    shift_next  = s_axis_tdata[13:7];
                    in_key_next = bsl_pkg::KEY_WIDTH'(signed'(s_axis_tdata[45:14]));
                    state_next  = S_EXEC;
                end
            end
            S_EXEC:
            begin
                ok_next    = 1'b0;
                rd_next    = '0;
                state_next = S_CHECK;
                case (op_reg)
                    bsl_pkg::OPC_PUSH_FRONT:
                    begin
                        if (has_room)
                        begin
                            cmd.op     = bsl_pkg::CELL_INSERT;
                            cmd.pos    = '0;
                            count_next = count_reg + bsl_pkg::CNT_W'(1);
                            ok_next    = 1'b1;
                        end
                    end
                    bsl_pkg::OPC_POP_FRONT:
                    begin
                        if (count_reg != '0)
                        begin
                            cmd.op     = bsl_pkg::CELL_REMOVE_FRONT;
                            count_next = count_reg - bsl_pkg::CNT_W'(1);
                            ok_next    = 1'b1;
                        end
                    end
                    bsl_pkg::OPC_INSERT:
                    begin
                        if (has_room && (pos_w < count_w))
                        begin
                            cmd.op     = bsl_pkg::CELL_INSERT;
                            count_next = count_reg + bsl_pkg::CNT_W'(1);
                            ok_next    = 1'b1;
                        end
                    end
                    bsl_pkg::OPC_GET:
                    begin
                        if (pos_w < count_w)
                        begin
                            rd_next = bsl_pkg::IN_KEY_W'(signed'(rd_any));
                            ok_next = 1'b1;
                        end
                        else
                        begin
                            rd_next = '1;
                        end
                    end
                    bsl_pkg::OPC_PUSH_BACK:
                    begin
                        if (has_room)
                        begin
                            cmd.op     = bsl_pkg::CELL_APPEND;
                            count_next = count_reg + bsl_pkg::CNT_W'(1);
                            ok_next    = 1'b1;
                        end
                    end
                    bsl_pkg::OPC_POP_BACK:
                    begin
                        if (count_reg != '0)
                        begin
                            count_next = count_reg - bsl_pkg::CNT_W'(1);
                            ok_next    = 1'b1;
                        end
                    end
                    bsl_pkg::OPC_ROTATE:
                    begin
                        if (shift_w < count_w)
                        begin
                            ok_next = 1'b1;
                            if (shift_w != '0)
                            begin
                                rot_left_next = shift_w;
                                state_next    = S_ROT;
                            end
                        end
                    end
                    default:
                    begin
                        ok_next = 1'b0;
                    end
                endcase
            end
            S_ROT:
            begin
                cmd.op        = bsl_pkg::CELL_ROTATE;
                rot_left_next = rot_left_reg - bsl_pkg::CMP_W'(1);
                if (rot_left_reg == bsl_pkg::CMP_W'(1))
                begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                // The cells register their ordering flags over the settled keys here.
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (!m_tvalid_reg || m_axis_tready)
                begin
                    m_tvalid_next  = 1'b1;
                    res_ok_next    = ok_reg;
                    res_rd_next    = rd_reg;
                    res_count_next = bsl_pkg::OUT_CNT_W'(count_reg);
                    res_empty_next = (count_reg == '0);
                    res_asc_next   = &order_vec;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            rot_left_reg <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            rot_left_reg <= rot_left_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        pos_reg       <= pos_next;
        shift_reg     <= shift_next;
        in_key_reg    <= in_key_next;
        ok_reg        <= ok_next;
        rd_reg        <= rd_next;
        res_ok_reg    <= res_ok_next;
        res_rd_reg    <= res_rd_next;
        res_count_reg <= res_count_next;
        res_empty_reg <= res_empty_next;
        res_asc_reg   <= res_asc_next;
    end

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = m_tvalid_reg;
    assign m_axis_tdata  = {6'b0, res_asc_reg, res_empty_reg, res_count_reg,
                            res_rd_reg, res_ok_reg};

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= bsl_pkg::CNT_W'(bsl_pkg::CAPACITY))
        else $error("entry count exceeds capacity");

    a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == S_EXEC))
        else $error("accepted word did not start execution");

    a_rot_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ROT) |-> (rot_left_reg != '0) && (rot_left_reg < count_w))
        else $error("rotation step count out of range");

    a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid_reg |-> (res_empty_reg == (res_count_reg == '0)))
        else $error("empty flag disagrees with count");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_EXEC) |=> (count_reg == $past(count_reg)))
        else $error("count changed outside execution");

endmodule

FILE: tb/tb_bounded_sequence_list_top.sv
// Self-checking testbench for the bounded sequence list: directed table, then random segments.
module tb_bounded_sequence_list_top;

    localparam logic [2:0] OPC_UNUSED   = 3'd7;
    localparam int         RANDOM_ITEMS = 1500;
    localparam int         HOLD_CYCLES  = 300;
    localparam int         TAIL_CYCLES  = 100;
    localparam int         REPORT_LIMIT = 10;
    localparam int         DIRECTED_N   = 25;

    typedef struct packed {
        logic        ok;
        logic [31:0] read_value;
        logic [6:0]  count;
        logic        is_empty;
        logic        ascending;
    } list_result_t;

    typedef struct {
        logic [2:0]   op;
        logic [6:0]   pos;
        logic [6:0]   shift;
        logic [31:0]  key;
        bit           typed;
        list_result_t res;
    } stim_row_t;

    typedef enum { MODE_FILL, MODE_DRAIN, MODE_MIXED, MODE_SORTED, MODE_PROBE } list_mode_t;

    localparam list_result_t EMPTY_REFUSED = {1'b0, 32'd0, 7'd0, 1'b1, 1'b1};
    localparam list_result_t GET_EMPTY     = {1'b0, 32'hFFFF_FFFF, 7'd0, 1'b1, 1'b1};
    localparam list_result_t NOT_TYPED     = '0;

    logic                           clk;
    logic                           rst_n;
    logic                           s_axis_tvalid;
    logic                           s_axis_tready;
    logic [bsl_pkg::IN_DATA_W-1:0]  s_axis_tdata;
    logic [bsl_pkg::OPC_W-1:0]      s_axis_tuser;
    logic                           m_axis_tvalid;
    logic                           m_axis_tready;
    logic [bsl_pkg::OUT_DATA_W-1:0] m_axis_tdata;

    logic signed [31:0] shadow_keys [bsl_pkg::CAPACITY];
    int                 shadow_count;
    list_result_t       pending_results [$];
    int                 mismatch_count;
    bit                 idle_on;
    bit                 hold_request;
    stim_row_t          directed_rows [DIRECTED_N];

    bounded_sequence_list_top dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial clk = 1'b0;
    always #1 clk = ~clk;

    // Applies one operation to the shadow list and returns the word the block should give.
    function automatic list_result_t apply_list_op(logic [2:0] op, logic [6:0] pos,
                                                   logic [6:0] shift, logic signed [31:0] key);
        list_result_t       r;
        logic signed [31:0] rotated [bsl_pkg::CAPACITY];
        int                 i;
        r = '0;
        case (op)
            bsl_pkg::OPC_PUSH_FRONT:
                if (shadow_count < bsl_pkg::CAPACITY)
                begin
                    for (i = shadow_count; i > 0; i--)
                        shadow_keys[i] = shadow_keys[i-1];
                    shadow_keys[0] = key;
                    shadow_count++;
                    r.ok = 1'b1;
                end
            bsl_pkg::OPC_POP_FRONT:
                if (shadow_count > 0)
                begin
                    for (i = 0; i < shadow_count - 1; i++)
                        shadow_keys[i] = shadow_keys[i+1];
                    shadow_count--;
                    r.ok = 1'b1;
                end
            bsl_pkg::OPC_INSERT:
                if (shadow_count < bsl_pkg::CAPACITY && pos < shadow_count)
                begin
                    for (i = shadow_count; i > pos; i--)
                        shadow_keys[i] = shadow_keys[i-1];
                    shadow_keys[pos] = key;
                    shadow_count++;
                    r.ok = 1'b1;
                end
            bsl_pkg::OPC_GET:
                if (pos < shadow_count)
                begin
                    r.read_value = shadow_keys[pos];
                    r.ok = 1'b1;
                end
                else
                    r.read_value = '1;
            bsl_pkg::OPC_PUSH_BACK:
                if (shadow_count < bsl_pkg::CAPACITY)
                begin
                    shadow_keys[shadow_count] = key;
                    shadow_count++;
                    r.ok = 1'b1;
                end
            bsl_pkg::OPC_POP_BACK:
                if (shadow_count > 0)
                begin
                    shadow_count--;
                    r.ok = 1'b1;
                end
            bsl_pkg::OPC_ROTATE:
                if (shift < shadow_count)
                begin
                    for (i = 0; i < shadow_count; i++)
                        rotated[i] = shadow_keys[(i + shift) % shadow_count];
                    for (i = 0; i < shadow_count; i++)
                        shadow_keys[i] = rotated[i];
                    r.ok = 1'b1;
                end
            default:
                ;
        endcase
        r.count     = shadow_count[6:0];
        r.is_empty  = (shadow_count == 0);
        r.ascending = 1'b1;
        for (i = 1; i < shadow_count; i++)
            if (shadow_keys[i-1] >= shadow_keys[i])
                r.ascending = 1'b0;
        return r;
    endfunction

    // Mostly short gaps, now and then a long one.
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Mostly a valid index below the limit, sometimes the limit itself, sometimes anything.
    function automatic logic [6:0] pick_index(int limit, bit low_bias);
        int r;
        r = $urandom_range(0, 99);
        if (r < 80 && limit > 0)
            return low_bias ? 7'($urandom_range(0, (limit - 1 < 7) ? limit - 1 : 7))
                            : 7'($urandom_range(0, limit - 1));
        else if (r < 90)
            return 7'(limit);
        return 7'($urandom_range(0, 127));
    endfunction

    function automatic logic [31:0] pick_key();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return $urandom;
        else if (r < 80)
            return $urandom_range(0, 200) - 100;
        case ($urandom_range(0, 3))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'h0000_0000;
            default: return 32'hFFFF_FFFF;
        endcase
    endfunction

    // Called at a falling edge; returns at the falling edge after the word is taken.
    task automatic send_word(logic [2:0] op, logic [6:0] pos, logic [6:0] shift,
                             logic [31:0] key, bit typed, list_result_t typed_res);
        int           gap;
        list_result_t predicted;
        list_result_t queued;
        gap = idle_on ? idle_len() : 0;
        if (gap > 0)
        begin
            s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tdata  = {2'b00, key, shift, pos};
        s_axis_tuser  = op;
        s_axis_tvalid = 1'b1;
        do
            @(posedge clk);
        while (!s_axis_tready);
        predicted = apply_list_op(op, pos, shift, key);
        queued    = typed ? typed_res : predicted;
        pending_results = {pending_results, queued};
        @(negedge clk);
    endtask

    task automatic wait_drained();
        s_axis_tvalid = 1'b0;
        @(negedge clk);
        while (pending_results.size() != 0)
            @(negedge clk);
    endtask

    // Result checker.
    always @(posedge clk)
    begin
        list_result_t got;
        list_result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.ok         = m_axis_tdata[0];
            got.read_value = m_axis_tdata[32:1];
            got.count      = m_axis_tdata[39:33];
            got.is_empty   = m_axis_tdata[40];
            got.ascending  = m_axis_tdata[41];
            if (pending_results.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT)
                    $display("unexpected word: ok=%0d rd=%h cnt=%0d empty=%0d asc=%0d",
                             got.ok, got.read_value, got.count, got.is_empty, got.ascending);
            end
            else
            begin
                want = pending_results[0];
                pending_results.delete(0);
                if (got !== want)
                begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT)
                        $display({"mismatch: expected ok=%0d rd=%h cnt=%0d empty=%0d asc=%0d,",
                                  " got ok=%0d rd=%h cnt=%0d empty=%0d asc=%0d"},
                                 want.ok, want.read_value, want.count, want.is_empty,
                                 want.ascending, got.ok, got.read_value, got.count,
                                 got.is_empty, got.ascending);
                end
            end
        end
    end

    // Receiver: random stalls, plus one long hold-off counted here.
    initial
    begin
        int rx_wait;
        bit hold_done;
        rx_wait   = 0;
        hold_done = 1'b0;
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_request && !hold_done)
            begin
                m_axis_tready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_done = 1'b1;
            end
            else if (rx_wait > 0)
            begin
                m_axis_tready = 1'b0;
                rx_wait--;
            end
            else
            begin
                m_axis_tready = 1'b1;
                if (idle_on && $urandom_range(0, 3) == 0)
                    rx_wait = idle_len();
            end
        end
    end

    initial
    begin
        #2000000;
        $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        int                 n;
        int                 seg;
        int                 seg_len;
        int                 k;
        int                 r;
        int                 random_sent;
        list_mode_t         mode;
        logic [2:0]         op;
        logic [6:0]         pos;
        logic [6:0]         shift;
        logic [31:0]        key;
        logic signed [31:0] sorted_next;

        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        s_axis_tuser   = '0;
        rst_n          = 1'b0;
        shadow_count   = 0;
        mismatch_count = 0;
        idle_on        = 1'b1;
        hold_request   = 1'b0;
        random_sent    = 0;
        sorted_next    = 0;

        directed_rows = '{
            '{bsl_pkg::OPC_POP_FRONT,  7'd0,   7'd0,   32'd0,         1'b1, EMPTY_REFUSED},
            '{bsl_pkg::OPC_POP_BACK,   7'd0,   7'd0,   32'd0,         1'b1, EMPTY_REFUSED},
            '{bsl_pkg::OPC_GET,        7'd0,   7'd0,   32'd0,         1'b1, GET_EMPTY},
            '{bsl_pkg::OPC_ROTATE,     7'd0,   7'd0,   32'd0,         1'b1, EMPTY_REFUSED},
            '{bsl_pkg::OPC_INSERT,     7'd0,   7'd0,   32'd5,         1'b1, EMPTY_REFUSED},
            '{OPC_UNUSED,              7'd127, 7'd127, 32'hFFFF_FFFF, 1'b1, EMPTY_REFUSED},
            '{bsl_pkg::OPC_PUSH_BACK,  7'd0,   7'd0,   32'h8000_0000, 1'b1,
              {1'b1, 32'd0, 7'd1, 1'b0, 1'b1}},
            '{bsl_pkg::OPC_PUSH_BACK,  7'd0,   7'd0,   32'h7FFF_FFFF, 1'b1,
              {1'b1, 32'd0, 7'd2, 1'b0, 1'b1}},
            '{bsl_pkg::OPC_GET,        7'd0,   7'd0,   32'd0,         1'b1,
              {1'b1, 32'h8000_0000, 7'd2, 1'b0, 1'b1}},
            '{bsl_pkg::OPC_GET,        7'd1,   7'd0,   32'd0,         1'b1,
              {1'b1, 32'h7FFF_FFFF, 7'd2, 1'b0, 1'b1}},
            '{bsl_pkg::OPC_GET,        7'd2,   7'd0,   32'd0,         1'b1,
              {1'b0, 32'hFFFF_FFFF, 7'd2, 1'b0, 1'b1}},
            '{bsl_pkg::OPC_GET,        7'd127, 7'd0,   32'd0,         1'b1,
              {1'b0, 32'hFFFF_FFFF, 7'd2, 1'b0, 1'b1}},
            '{bsl_pkg::OPC_PUSH_FRONT, 7'd0,   7'd0,   32'd0,         1'b1,
              {1'b1, 32'd0, 7'd3, 1'b0, 1'b0}},
            '{bsl_pkg::OPC_INSERT,     7'd1,   7'd0,   32'hFFFF_FFFF, 1'b0, NOT_TYPED},
            '{bsl_pkg::OPC_INSERT,     7'd4,   7'd0,   32'd9,         1'b0, NOT_TYPED},
            '{bsl_pkg::OPC_INSERT,     7'd127, 7'd0,   32'd9,         1'b0, NOT_TYPED},
            '{bsl_pkg::OPC_ROTATE,     7'd0,   7'd3,   32'd0,         1'b0, NOT_TYPED},
            '{bsl_pkg::OPC_ROTATE,     7'd0,   7'd4,   32'd0,         1'b0, NOT_TYPED},
            '{bsl_pkg::OPC_ROTATE,     7'd0,   7'd127, 32'd0,         1'b0, NOT_TYPED},
            '{bsl_pkg::OPC_ROTATE,     7'd0,   7'd0,   32'd0,         1'b0, NOT_TYPED},
            '{bsl_pkg::OPC_GET,        7'd64,  7'd0,   32'd0,         1'b0, NOT_TYPED},
            '{bsl_pkg::OPC_POP_FRONT,  7'd0,   7'd0,   32'd0,         1'b0, NOT_TYPED},
            '{bsl_pkg::OPC_POP_BACK,   7'd0,   7'd0,   32'd0,         1'b0, NOT_TYPED},
            '{OPC_UNUSED,              7'd0,   7'd0,   32'd0,         1'b0, NOT_TYPED},
            '{bsl_pkg::OPC_PUSH_FRONT, 7'd0,   7'd0,   32'h2AAA_AAAA, 1'b0, NOT_TYPED}
        };

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        for (n = 0; n < DIRECTED_N; n++)
            send_word(directed_rows[n].op, directed_rows[n].pos, directed_rows[n].shift,
                      directed_rows[n].key, directed_rows[n].typed, directed_rows[n].res);
        wait_drained();

        // The first segment fills the store and keeps pushing into it once it is full.
        for (seg = 0; random_sent < RANDOM_ITEMS; seg++)
        begin
            mode    = (seg == 0) ? MODE_FILL : list_mode_t'($urandom_range(0, 4));
            seg_len = (seg == 0) ? 110 : $urandom_range(30, 120);
            idle_on = (seg == 0) ? 1'b1 : ($urandom_range(0, 3) != 0);
            if (seg == 2)
                hold_request = 1'b1;
            if (mode == MODE_SORTED)
            begin
                while (shadow_count > 0)
                begin
                    send_word(bsl_pkg::OPC_POP_BACK, pick_index(0, 1'b0), pick_index(0, 1'b0),
                              pick_key(), 1'b0, NOT_TYPED);
                    random_sent++;
                end
                sorted_next = $signed($urandom_range(0, 1000)) - 32'sd2000000;
            end
            for (k = 0; k < seg_len; k++)
            begin
                r     = $urandom_range(0, 99);
                pos   = pick_index(shadow_count, 1'b0);
                shift = pick_index(shadow_count, 1'($urandom_range(0, 1)));
                key   = pick_key();
                case (mode)
                    MODE_FILL:
                        if (r < 35)      op = bsl_pkg::OPC_PUSH_BACK;
                        else if (r < 65) op = bsl_pkg::OPC_PUSH_FRONT;
                        else if (r < 90) op = bsl_pkg::OPC_INSERT;
                        else if (r < 95) op = bsl_pkg::OPC_GET;
                        else             op = 3'($urandom_range(0, 7));
                    MODE_DRAIN:
                        if (r < 35)      op = bsl_pkg::OPC_POP_FRONT;
                        else if (r < 70) op = bsl_pkg::OPC_POP_BACK;
                        else if (r < 80) op = bsl_pkg::OPC_GET;
                        else if (r < 90) op = bsl_pkg::OPC_ROTATE;
                        else             op = 3'($urandom_range(0, 7));
                    MODE_SORTED:
                        if (r < 75)
                        begin
                            op          = bsl_pkg::OPC_PUSH_BACK;
                            key         = sorted_next;
                            sorted_next = sorted_next + $urandom_range(1, 5000);
                        end
                        else if (r < 85) op = bsl_pkg::OPC_GET;
                        else if (r < 92) op = bsl_pkg::OPC_POP_FRONT;
                        else
                        begin
                            // A rotate by zero leaves the order, and so the flag, intact.
                            op    = bsl_pkg::OPC_ROTATE;
                            shift = 7'd0;
                        end
                    MODE_PROBE:
                        if (r < 40)      op = bsl_pkg::OPC_GET;
                        else if (r < 80) op = bsl_pkg::OPC_ROTATE;
                        else if (r < 95) op = bsl_pkg::OPC_INSERT;
                        else             op = bsl_pkg::OPC_PUSH_BACK;
                    default:
                        op = 3'($urandom_range(0, 7));
                endcase
                send_word(op, pos, shift, key, 1'b0, NOT_TYPED);
                random_sent++;
            end
            if ($urandom_range(0, 3) == 0)
                wait_drained();
        end
        s_axis_tvalid = 1'b0;

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

FILE: files.f
rtl/bsl_pkg.sv
rtl/bsl_cell.sv
rtl/bounded_sequence_list_top.sv
tb/tb_bounded_sequence_list_top.sv
